[hdl/tto_pkg.sv]
// shared types and constants for the terminator / timeout deframer
`timescale 1ns / 1ps
package tto_pkg;

  localparam int MAX_TERMINATOR = 8;
  localparam int MAX_FRAME      = 1048576;

  localparam int BYTE_W    = 8;
  localparam int TLEN_W    = 4;
  localparam int TERM_W    = BYTE_W * MAX_TERMINATOR;
  localparam int TSEL_W    = (MAX_TERMINATOR > 1) ? $clog2(MAX_TERMINATOR) : 1;
  localparam int LEN_W     = 21;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TERM_LEN   = 2'd0,
    CFG_TERM_BYTES = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    KIND_MID     = 3'd0,
    KIND_TERM    = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_ABORT   = 3'd3,
    KIND_PASS    = 3'd4
  } kind_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
    logic              chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    kind_t             kind;
    logic [LEN_W-1:0]  frame_length;
    logic              chunk_last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[hdl/tto_cell.sv]
// one history byte of the terminator compare row
`timescale 1ns / 1ps
module tto_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tto_pkg::cell_ctrl_t        ctrl,
  input  logic [tto_pkg::BYTE_W-1:0] byte_in,
  input  logic [tto_pkg::BYTE_W-1:0] want,
  input  logic                       active,
  output logic [tto_pkg::BYTE_W-1:0] byte_q,
  output logic                       hit
);
  import tto_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = '0;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // compare against the byte this cell will hold after the shift
  assign hit    = !active || (byte_in == want);
  assign byte_q = byte_r;

endmodule

[hdl/tto_outbuf.sv]
// output register with one skid entry
`timescale 1ns / 1ps
module tto_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  tto_pkg::out_item_t res,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output tto_pkg::out_item_t out_data
);
  import tto_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_fire;

  assign out_fire = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_nxt       = res;
      out_valid_nxt = res_valid;
    end else begin
      skid_nxt       = res;
      skid_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/terminator_timeout_deframer.sv]
// top level: byte stream deframer cutting on terminator match or idle timeout, aborting overlong frames
// a result is registered into the output register, or into the skid entry while the output register is held
// throughput: one transaction per cycle while the output skid entry is empty
// a result waiting at the output does not stall input; a second waiting result does
// reset: synchronous active-low rst_n clears registers, frame history and counters
// after reset framing is off (pass-through) until the registers are written
`timescale 1ns / 1ps
module terminator_timeout_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tto_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tto_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [tto_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tto_pkg::CFG_W-1:0]     cfg_wdata
);
  import tto_pkg::*;

  // configuration registers
  logic [TLEN_W-1:0] term_len_r;
  logic [TERM_W-1:0] term_bytes_r;
  logic [TICK_W-1:0] timeout_r;

  // frame state
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] silence_r, silence_nxt;

  logic [BYTE_W-1:0] cell_q   [MAX_TERMINATOR];
  logic [BYTE_W-1:0] cell_d   [MAX_TERMINATOR];
  logic [BYTE_W-1:0] cell_want[MAX_TERMINATOR];
  logic [MAX_TERMINATOR-1:0] cell_hit;
  logic [MAX_TERMINATOR-1:0] cell_act;
  cell_ctrl_t        cell_ctrl;

  logic              accept;
  logic              framing;
  logic              overflow;
  logic              term_hit;
  logic [TLEN_W-1:0] tlen;
  logic [LEN_W-1:0]  count_inc;
  logic [TICK_W-1:0] silence_inc;
  logic              res_valid;
  out_item_t         res;
  logic              space;

  // config writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_len_r   <= '0;
      term_bytes_r <= '0;
      timeout_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TERM_LEN:   term_len_r   <= cfg_wdata[TLEN_W-1:0];
        CFG_TERM_BYTES: term_bytes_r <= cfg_wdata[TERM_W-1:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized terminator length saturates
  assign tlen = (term_len_r > TLEN_W'(MAX_TERMINATOR)) ? TLEN_W'(MAX_TERMINATOR) : term_len_r;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  // cell row: newest byte enters cell 0, older bytes move one cell along per framed byte
  // cell j compares against terminator byte tlen-1-j
  genvar j;
  generate
    for (j = 0; j < MAX_TERMINATOR; j++) begin : g_cell
      logic [TLEN_W-1:0] sel;

      if (j == 0) begin : g_head
        assign cell_d[j] = in_data.rx_byte;
      end else begin : g_link
        assign cell_d[j] = cell_q[j-1];
      end

      assign sel         = tlen - TLEN_W'(1) - TLEN_W'(j);
      assign cell_act[j] = TLEN_W'(j) < tlen;
      assign cell_want[j] = term_bytes_r[{sel[TSEL_W-1:0], 3'b000} +: BYTE_W];

      tto_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .byte_in (cell_d[j]),
        .want    (cell_want[j]),
        .active  (cell_act[j]),
        .byte_q  (cell_q[j]),
        .hit     (cell_hit[j])
      );
    end
  endgenerate

  assign framing     = (tlen != '0) || (timeout_r != '0);
  assign overflow    = count_r >= LEN_W'(MAX_FRAME);
  assign count_inc   = count_r + LEN_W'(1);
  assign silence_inc = (silence_r == '1) ? silence_r : silence_r + TICK_W'(1);
  // match only once the frame holds the whole terminator
  assign term_hit    = (tlen != '0) && (LEN_W'(tlen) <= count_inc) && (&cell_hit);

  always_comb begin
    res_valid       = 1'b0;
    res             = '0;
    res.kind        = KIND_MID;
    count_nxt       = count_r;
    silence_nxt     = silence_r;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.clear = 1'b0;
    if (accept) begin
      priority if (in_data.action == ACT_TICK) begin
        // tick with timeout off leaves everything alone
        if (timeout_r != '0) begin
          silence_nxt = silence_inc;
          if (count_r != '0 && silence_inc >= timeout_r) begin
            res_valid        = 1'b1;
            res.kind         = KIND_TIMEOUT;
            res.frame_length = count_r;
            cell_ctrl.clear  = 1'b1;
          end
        end
      end else if (!framing) begin
        // pass-through, frame state untouched
        res_valid      = 1'b1;
        res.out_byte   = in_data.rx_byte;
        res.kind       = KIND_PASS;
        res.chunk_last = in_data.chunk_end;
      end else if (overflow) begin
        // frame too long: drop it together with this byte
        res_valid        = 1'b1;
        res.out_byte     = in_data.rx_byte;
        res.kind         = KIND_ABORT;
        res.frame_length = LEN_W'(MAX_FRAME);
        cell_ctrl.clear  = 1'b1;
      end else begin
        cell_ctrl.shift  = 1'b1;
        count_nxt        = count_inc;
        silence_nxt      = '0;
        res_valid        = 1'b1;
        res.out_byte     = in_data.rx_byte;
        res.frame_length = count_inc;
        if (term_hit) begin
          res.kind        = KIND_TERM;
          cell_ctrl.clear = 1'b1;
        end else begin
          res.kind = KIND_MID;
        end
      end
      if (cell_ctrl.clear) begin
        count_nxt   = '0;
        silence_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      silence_r <= '0;
    end else begin
      count_r   <= count_nxt;
      silence_r <= silence_nxt;
    end
  end

  tto_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // frame count never passes the frame limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEN_W'(MAX_FRAME))
    else $error("frame count above limit");

  // a framed byte always restarts the silence count
  a_byte_clears_silence: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.action == ACT_BYTE && framing) |=> (silence_r == '0))
    else $error("silence not cleared by framed byte");

  // a terminator cut leaves an empty frame
  a_term_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.kind == KIND_TERM) |=> (count_r == '0))
    else $error("frame not cleared after terminator");

  // input stalls only while a result is still waiting at the output
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready) || $past(out_valid && !out_ready))
    else $error("input stalled with free output buffer");
`endif

endmodule
